// ----- hdl/cubic_window_control_unit_macros.svh -----
// Assertion macros shared by the control unit modules.
`ifndef CUBIC_WINDOW_CONTROL_UNIT_MACROS_SVH
`define CUBIC_WINDOW_CONTROL_UNIT_MACROS_SVH

// Antecedent on one edge, consequent on the next.
`define CWCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that holds at every edge out of reset.
`define CWCU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

// ----- hdl/cwcu_pkg.sv -----
`default_nettype none
package cwcu_pkg;

	localparam int WinW      = 16;
	localparam int TimeW     = 32;
	localparam int ThrW      = WinW + 8;
	localparam int CfgW      = 16;
	localparam int DivW      = 49;
	localparam int DivCntW   = 6;
	localparam int RootW     = 20;
	localparam int RootCntW  = 5;
	localparam int MulAW     = 40;
	localparam int MulBW     = 20;
	localparam int ProdW     = MulAW + MulBW;
	localparam int TermW     = 46;
	localparam int TgtW      = 47;

	localparam logic [CfgW-1:0] GainReset  = 16'd26214;
	localparam logic [CfgW-1:0] BetaReset  = 16'd45875;
	localparam logic [ThrW-1:0] ThrReset   = 24'd8192;
	localparam logic [ThrW-1:0] ThrFloor   = 24'd512;

	// ceil(2^44 / 125) split at bit 20; exact floor(n / 125) for n below 2^37
	localparam logic [MulBW-1:0] RecipHi = 20'd134217;
	localparam logic [MulBW-1:0] RecipLo = 20'd763364;

	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_BETA = 1'b1;

	localparam logic OP_DATA    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_GROW, S_TO_MUL, S_TO_APPLY,
		S_T_LO, S_T_HI, S_T_SAVE, S_X_MUL, S_X_LOAD, S_X_DIV, S_X_SAVE,
		S_R_SQ, S_R_CUBE, S_R_CMP, S_M, S_M_SQ, S_M_CUBE,
		S_C_HI, S_C_LO, S_C_SUM, S_C_DEC, S_FINISH
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_GROW, CMD_TO_MUL, CMD_TO_APPLY,
		CMD_T_LO, CMD_T_HI, CMD_DIV_STEP, CMD_T_SAVE, CMD_X_MUL, CMD_X_LOAD, CMD_X_SAVE,
		CMD_R_SQ, CMD_R_CUBE, CMD_R_CMP, CMD_M, CMD_M_SQ, CMD_M_CUBE,
		CMD_C_HI, CMD_C_LO, CMD_C_SUM, CMD_C_DEC, CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic is_timeout;
		logic in_slow_start;
		logic div_last;
		logic root_last;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/cwcu_dp.sv -----
`default_nettype none
`include "cubic_window_control_unit_macros.svh"
module cwcu_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire cwcu_pkg::cmd_t              cmd,
	output cwcu_pkg::status_t                status,
	input  wire                              op,
	input  wire  [cwcu_pkg::TimeW-1:0]       now_ms,
	input  wire                              cfg_wr,
	input  wire                              cfg_index,
	input  wire  [cwcu_pkg::CfgW-1:0]        cfg_data,
	output logic [cwcu_pkg::WinW-1:0]        window,
	output logic                             slow_start
);
	import cwcu_pkg::*;

	logic [CfgW-1:0]    gain_q, beta_q;
	logic [WinW-1:0]    cwnd_q, peak_q;
	logic [ThrW-1:0]    thresh_q;
	logic [TimeW-1:0]   epoch_q, now_q;
	logic               op_q;
	logic [TimeW-1:0]   t8_q, m_q;
	logic [56:0]        t_lo_q;
	logic [DivW-1:0]    x_q, quo_q;
	logic [CfgW-1:0]    rem_q, dvs_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic [RootW-1:0]   r_q;
	logic [RootCntW-1:0] bit_q;
	logic [ProdW-1:0]   prod_q, m3_q;
	logic [55:0]        hi_q;
	logic [TermW-1:0]   term_q;
	logic               neg_q, sat_q;
	logic [WinW-1:0]    window_q;
	logic               slow_q;

	logic [MulAW-1:0]   mul_a;
	logic [MulBW-1:0]   mul_b;
	logic [ProdW-1:0]   mul_p;
	logic [TimeW+4:0]   t_num;
	logic [75:0]        t_sum;
	logic [RootW-1:0]   cand;
	logic [CfgW:0]      trial, diff;
	logic               ge;
	logic [CfgW-1:0]    gain_nz;
	logic [CfgW:0]      one_minus;
	logic [WinW-1:0]    w_nz;
	logic [ThrW-1:0]    th_raw, th_new;
	logic [WinW-1:0]    cw_new;
	logic [TimeW-1:0]   k_ext;
	logic [75:0]        term_sum;
	logic [TgtW-1:0]    base, term_ext, target;
	logic               grow_curve, slow_now;

	assign gain_nz   = (gain_q == '0) ? CfgW'(1) : gain_q;
	assign one_minus = (CfgW+1)'(1 << CfgW) - {1'b0, beta_q};
	assign w_nz      = (cwnd_q == '0) ? WinW'(1) : cwnd_q;
	assign cand      = r_q | (RootW'(1) << bit_q);
	assign k_ext     = TimeW'(r_q);
	assign slow_now  = {cwnd_q, 8'b0} < thresh_q;

	// elapsed ms times 32, to be divided by 125 for Q8 seconds
	assign t_num = {now_q - epoch_q, 5'b0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd)
			CMD_T_LO: begin
				mul_a = MulAW'(t_num);
				mul_b = RecipLo;
			end
			CMD_T_HI: begin
				mul_a = MulAW'(t_num);
				mul_b = RecipHi;
			end
			CMD_TO_MUL: begin
				mul_a = MulAW'(w_nz);
				mul_b = MulBW'(beta_q);
			end
			CMD_X_MUL: begin
				mul_a = MulAW'(peak_q);
				mul_b = MulBW'(one_minus);
			end
			CMD_R_SQ: begin
				mul_a = MulAW'(cand);
				mul_b = cand;
			end
			CMD_R_CUBE: begin
				mul_a = prod_q[MulAW-1:0];
				mul_b = cand;
			end
			CMD_M_SQ: begin
				mul_a = MulAW'(m_q[RootW-1:0]);
				mul_b = m_q[RootW-1:0];
			end
			CMD_M_CUBE: begin
				mul_a = prod_q[MulAW-1:0];
				mul_b = m_q[RootW-1:0];
			end
			CMD_C_HI: begin
				mul_a = prod_q[ProdW-1:MulBW];
				mul_b = MulBW'(gain_nz);
			end
			CMD_C_LO: begin
				mul_a = MulAW'(m3_q[MulBW-1:0]);
				mul_b = MulBW'(gain_nz);
			end
			default: ;
		endcase
	end
	assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

	// join the two reciprocal partial products, keep bits 44 and up
	assign t_sum = {prod_q[55:0], 20'b0} + 76'(t_lo_q);

	// one quotient bit per step, restoring
	assign trial = {rem_q, quo_q[DivW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	assign th_raw = prod_q[ThrW+7:8];
	assign th_new = (th_raw < ThrFloor) ? ThrFloor : th_raw;
	assign cw_new = (th_new[ThrW-1:8] == '0) ? WinW'(1) : th_new[ThrW-1:8];

	assign term_sum = {hi_q, 20'b0} + 76'(prod_q[35:0]);
	assign base     = TgtW'({peak_q, 8'b0});
	assign term_ext = TgtW'(term_q);
	always_comb begin
		if (neg_q) target = (term_ext >= base) ? '0 : base - term_ext;
		else       target = base + term_ext;
	end
	assign grow_curve = target > TgtW'({cwnd_q, 8'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GainReset;
			beta_q   <= BetaReset;
			cwnd_q   <= WinW'(1);
			peak_q   <= WinW'(1);
			thresh_q <= ThrReset;
			epoch_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_GAIN: gain_q <= cfg_data;
					REG_BETA: beta_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd)
				CMD_TO_APPLY: begin
					peak_q   <= w_nz;
					thresh_q <= th_new;
					cwnd_q   <= cw_new;
					epoch_q  <= now_q;
				end
				CMD_GROW: if (cwnd_q != '1) cwnd_q <= cwnd_q + WinW'(1);
				CMD_C_DEC: if (grow_curve && cwnd_q != '1) cwnd_q <= cwnd_q + WinW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q  <= op;
				now_q <= now_ms;
			end
			CMD_T_HI: t_lo_q <= prod_q[56:0];
			CMD_T_SAVE: t8_q <= t_sum[75:44];
			CMD_X_LOAD: begin
				quo_q     <= {prod_q[32:0], 16'b0};
				dvs_q     <= gain_nz;
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			CMD_DIV_STEP: begin
				rem_q     <= ge ? diff[CfgW-1:0] : trial[CfgW-1:0];
				quo_q     <= {quo_q[DivW-2:0], ge};
				div_cnt_q <= div_cnt_q + DivCntW'(1);
			end
			CMD_X_SAVE: begin
				x_q   <= quo_q;
				r_q   <= '0;
				bit_q <= RootCntW'(RootW - 1);
			end
			CMD_R_CMP: begin
				if (prod_q <= ProdW'({x_q, 8'b0})) r_q <= cand;
				bit_q <= bit_q - RootCntW'(1);
			end
			CMD_M: begin
				neg_q <= t8_q < k_ext;
				m_q   <= (t8_q < k_ext) ? k_ext - t8_q : t8_q - k_ext;
				sat_q <= t8_q >= k_ext ? ((t8_q - k_ext) >= TimeW'(1 << RootW))
				                       : ((k_ext - t8_q) >= TimeW'(1 << RootW));
			end
			CMD_C_HI: m3_q <= prod_q;
			CMD_C_LO: hi_q <= prod_q[55:0];
			CMD_C_SUM: term_q <= sat_q ? TermW'(1) << (TermW - 1) : TermW'(term_sum[75:32]);
			CMD_OUT: begin
				window_q <= cwnd_q;
				slow_q   <= slow_now;
			end
			default: ;
		endcase
		case (cmd)
			CMD_T_LO, CMD_T_HI, CMD_TO_MUL, CMD_X_MUL, CMD_R_SQ, CMD_R_CUBE,
			CMD_M_SQ, CMD_M_CUBE, CMD_C_HI, CMD_C_LO: prod_q <= mul_p;
			default: ;
		endcase
	end

	assign status.is_timeout    = (op_q == OP_TIMEOUT);
	assign status.in_slow_start = slow_now;
	assign status.div_last      = (div_cnt_q == DivCntW'(DivW - 1));
	assign status.root_last     = (bit_q == '0);
	assign window     = window_q;
	assign slow_start = slow_q;

	`CWCU_ASSERT_ALWAYS(a_cwnd_nonzero, cwnd_q != '0, "window register reached zero")
	`CWCU_ASSERT_ALWAYS(a_thresh_floor, thresh_q >= ThrFloor, "threshold below 2.0")
endmodule
`default_nettype wire

// ----- hdl/cwcu_ctrl.sv -----
`default_nettype none
`include "cubic_window_control_unit_macros.svh"
module cwcu_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire                out_stall,
	input  wire cwcu_pkg::status_t status,
	output cwcu_pkg::cmd_t     cmd
);
	import cwcu_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_OUT)  out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd     = CMD_LOAD;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.is_timeout)         state_d = S_TO_MUL;
				else if (status.in_slow_start) state_d = S_GROW;
				else                           state_d = S_T_LO;
			end
			S_GROW: begin
				cmd     = CMD_GROW;
				state_d = S_FINISH;
			end
			S_TO_MUL: begin
				cmd     = CMD_TO_MUL;
				state_d = S_TO_APPLY;
			end
			S_TO_APPLY: begin
				cmd     = CMD_TO_APPLY;
				state_d = S_FINISH;
			end
			S_T_LO: begin
				cmd     = CMD_T_LO;
				state_d = S_T_HI;
			end
			S_T_HI: begin
				cmd     = CMD_T_HI;
				state_d = S_T_SAVE;
			end
			S_T_SAVE: begin
				cmd     = CMD_T_SAVE;
				state_d = S_X_MUL;
			end
			S_X_MUL: begin
				cmd     = CMD_X_MUL;
				state_d = S_X_LOAD;
			end
			S_X_LOAD: begin
				cmd     = CMD_X_LOAD;
				state_d = S_X_DIV;
			end
			S_X_DIV: begin
				cmd = CMD_DIV_STEP;
				if (status.div_last) state_d = S_X_SAVE;
			end
			S_X_SAVE: begin
				cmd     = CMD_X_SAVE;
				state_d = S_R_SQ;
			end
			S_R_SQ: begin
				cmd     = CMD_R_SQ;
				state_d = S_R_CUBE;
			end
			S_R_CUBE: begin
				cmd     = CMD_R_CUBE;
				state_d = S_R_CMP;
			end
			S_R_CMP: begin
				cmd     = CMD_R_CMP;
				state_d = status.root_last ? S_M : S_R_SQ;
			end
			S_M: begin
				cmd     = CMD_M;
				state_d = S_M_SQ;
			end
			S_M_SQ: begin
				cmd     = CMD_M_SQ;
				state_d = S_M_CUBE;
			end
			S_M_CUBE: begin
				cmd     = CMD_M_CUBE;
				state_d = S_C_HI;
			end
			S_C_HI: begin
				cmd     = CMD_C_HI;
				state_d = S_C_LO;
			end
			S_C_LO: begin
				cmd     = CMD_C_LO;
				state_d = S_C_SUM;
			end
			S_C_SUM: begin
				cmd     = CMD_C_SUM;
				state_d = S_C_DEC;
			end
			S_C_DEC: begin
				cmd     = CMD_C_DEC;
				state_d = S_FINISH;
			end
			S_FINISH: if (!out_valid_q || !out_stall) begin
				// slot is free or frees at this edge
				cmd     = CMD_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`CWCU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block took an item without going busy")
	`CWCU_ASSERT_NEXT(a_finish_fills, state_q == S_FINISH && !out_valid_q, out_valid_q,
		"finished item not presented")
	`CWCU_ASSERT_NEXT(a_root_exit, state_q == S_R_CMP && status.root_last, state_q == S_M,
		"root search did not stop after its last bit")
endmodule
`default_nettype wire

// ----- hdl/cubic_window_control_unit.sv -----
// Cubic congestion window controller.
// Input channel (in_valid, in_stall, op, now_ms): one event per item, op 0 for a
// data arrival and op 1 for a timeout, stamped with a millisecond time.
// Output channel (out_valid, out_stall, window, slow_start): one item per event
// giving the window after it and whether the window is below the threshold.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 writes the
// cubic gain, index 1 the decrease factor, both Q0.16; write only when idle.
// A data arrival on the cubic curve runs a reciprocal multiplication for the
// elapsed time in Q8 seconds, a 49-step restoring division for the curve
// origin, a 20-bit cube root that squares, cubes and compares for each bit,
// and the cube term, all on one shared 40x20 multiplier.
// A new item is taken once the previous one sits in the output register, so
// a result waiting on out_stall does not hold up the next event's work;
// only its own hand-over waits until the output register is free.
// Reset restores window 1, threshold 32.0, peak window 1, epoch 0 and the
// default gain and decrease factor; the output register comes up empty.
`default_nettype none
module cubic_window_control_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          op,
	input  wire  [cwcu_pkg::TimeW-1:0]   now_ms,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cwcu_pkg::WinW-1:0]    window,
	output logic                         slow_start,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire                          cfg_index,
	input  wire  [cwcu_pkg::CfgW-1:0]    cfg_data
);
	import cwcu_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	cwcu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cwcu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.now_ms     (now_ms),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.window     (window),
		.slow_start (slow_start)
	);
endmodule
`default_nettype wire
